// ===== hdl/mecss_pkg.sv =====
// Package for the minimum expected cost subset selector.
// Field widths, fixed constants and the controller-to-datapath command word.
// No dependencies.
package mecss_pkg;

  localparam int PROB_W = 17;
  localparam int COST_W = 16;
  localparam int PEN_W  = 16;
  localparam int MASK_W = 8;
  // Holds up to 15 access costs plus one miss term.
  localparam int SUM_W  = 20;

  localparam logic [PROB_W-1:0] ONE_Q16     = 17'h10000;
  localparam logic [PEN_W-1:0]  PEN_DEFAULT = 16'd1000;

  // One-cycle commands from controller to datapath.
  typedef struct packed {
    logic load;     // store accepted candidate
    logic start;    // open a search: best = penalty, mask = 0
    logic step;     // fold candidate k into the running subset
    logic take;     // candidate k is a member of the current subset
    logic fin_mul;  // miss term = P * penalty >> 16
    logic cmp;      // compare subset total against best
    logic push;     // load output word, close the request
  } mecss_cmd_t;

endpackage

// ===== hdl/mecss_if.sv =====
// Valid/ready channel interfaces: candidate input, result output, config write.
// Depends on mecss_pkg for field widths.
interface mecss_in_if;
  logic                          valid;
  logic                          ready;
  logic [mecss_pkg::PROB_W-1:0]  miss_prob;
  logic [mecss_pkg::COST_W-1:0]  query_cost;
  logic                          is_last;
  modport source (output valid, miss_prob, query_cost, is_last, input ready);
  modport sink   (input valid, miss_prob, query_cost, is_last, output ready);
endinterface

interface mecss_out_if;
  logic                          valid;
  logic                          ready;
  logic [mecss_pkg::MASK_W-1:0]  chosen_mask;
  logic [mecss_pkg::PEN_W-1:0]   best_cost;
  logic                          overflowed;
  modport source (output valid, chosen_mask, best_cost, overflowed, input ready);
  modport sink   (input valid, chosen_mask, best_cost, overflowed, output ready);
endinterface

interface mecss_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mecss_pkg::PEN_W-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/mecss_dp.sv =====
// Datapath: candidate store, running product/sum, best tracking, output word.
// Depends on mecss_pkg; driven by mecss_ctrl commands.
module mecss_dp #(
  parameter int MAX_PEERS = 8,
  parameter int IW        = 3,
  parameter int CW        = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mecss_pkg::mecss_cmd_t         cmd_i,
  input  logic [IW-1:0]                 k_i,
  input  logic [MAX_PEERS-1:0]          subset_i,
  input  logic [mecss_pkg::PROB_W-1:0]  miss_prob_i,
  input  logic [mecss_pkg::COST_W-1:0]  query_cost_i,
  input  logic                          cfg_we_i,
  input  logic [mecss_pkg::PEN_W-1:0]   cfg_data_i,
  output logic [CW-1:0]                 count_o,
  output logic [mecss_pkg::MASK_W-1:0]  chosen_mask_o,
  output logic [mecss_pkg::PEN_W-1:0]   best_cost_o,
  output logic                          overflowed_o
);
  import mecss_pkg::*;

  logic [PROB_W-1:0]    prob_q [MAX_PEERS];
  logic [COST_W-1:0]    cost_q [MAX_PEERS];
  logic [CW-1:0]        count_q;
  logic                 ovf_q;
  logic [PEN_W-1:0]     pen_q;
  logic [PROB_W-1:0]    p_q;
  logic [SUM_W-1:0]     sum_q;
  logic [PROB_W-1:0]    term_q;
  logic [SUM_W-1:0]     best_q;
  logic [MAX_PEERS-1:0] bmask_q;
  logic [MASK_W-1:0]    out_mask_q;
  logic [PEN_W-1:0]     out_cost_q;
  logic                 out_ovf_q;

  logic [PROB_W-1:0]        prob_sat;
  logic [2*PROB_W-1:0]      p_prod;
  logic [PROB_W+PEN_W-1:0]  t_prod;
  logic [SUM_W-1:0]         total;
  logic [MAX_PEERS+MASK_W-1:0] mask_ext;
  logic                     has_room;

  assign prob_sat = (miss_prob_i > ONE_Q16) ? ONE_Q16 : miss_prob_i;
  assign has_room = count_q < CW'(MAX_PEERS);
  assign p_prod   = p_q * prob_q[k_i];
  assign t_prod   = p_q * pen_q;
  assign total    = sum_q + SUM_W'(term_q);
  assign mask_ext = (MAX_PEERS+MASK_W)'(bmask_q);

  // control state: count, overflow flag, penalty register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      pen_q   <= PEN_DEFAULT;
    end else begin
      if (cfg_we_i) pen_q <= cfg_data_i;
      if (cmd_i.push) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.load) begin
        if (has_room) count_q <= count_q + CW'(1);
        else          ovf_q   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && has_room) begin
      prob_q[count_q[IW-1:0]] <= prob_sat;
      cost_q[count_q[IW-1:0]] <= query_cost_i;
    end
    if (cmd_i.start) begin
      best_q  <= SUM_W'(pen_q);
      bmask_q <= '0;
      p_q     <= ONE_Q16;
      sum_q   <= '0;
    end else if (cmd_i.step) begin
      if (cmd_i.take) begin
        sum_q <= sum_q + SUM_W'(cost_q[k_i]);
        p_q   <= p_prod[PROB_W+15:16];
      end
    end else if (cmd_i.cmp) begin
      if (total < best_q) begin
        best_q  <= total;
        bmask_q <= subset_i;
      end
      p_q   <= ONE_Q16;
      sum_q <= '0;
    end
    if (cmd_i.fin_mul) term_q <= PROB_W'(t_prod[PROB_W+PEN_W-1:16]);
    if (cmd_i.push) begin
      out_mask_q <= mask_ext[MASK_W-1:0];
      out_cost_q <= best_q[PEN_W-1:0];
      out_ovf_q  <= ovf_q;
    end
  end

  assign count_o       = count_q;
  assign chosen_mask_o = out_mask_q;
  assign best_cost_o   = out_cost_q;
  assign overflowed_o  = out_ovf_q;

endmodule

// ===== hdl/mecss_ctrl.sv =====
// Controller: load phase, subset/candidate sequencing, output handshake.
// Depends on mecss_pkg; drives mecss_dp.
module mecss_ctrl #(
  parameter int MAX_PEERS = 8,
  parameter int IW        = 3,
  parameter int CW        = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_last_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  logic [CW-1:0]          count_i,
  output mecss_pkg::mecss_cmd_t  cmd_o,
  output logic [IW-1:0]          k_o,
  output logic [MAX_PEERS-1:0]   subset_o
);
  import mecss_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_STEP, S_FMUL, S_CMP, S_PUSH
  } state_e;

  state_e               state_q, state_d;
  logic [IW-1:0]        k_q, k_d;
  logic [MAX_PEERS-1:0] s_q, s_d;
  logic                 out_valid_q, out_valid_d;

  logic [MAX_PEERS:0]   one_sh;
  logic [MAX_PEERS-1:0] full_mask;
  logic                 last_k, last_s, out_free;

  assign one_sh    = (MAX_PEERS+1)'(1) << count_i;
  assign full_mask = MAX_PEERS'(one_sh - (MAX_PEERS+1)'(1));
  assign last_k    = CW'(k_q) == (count_i - CW'(1));
  assign last_s    = s_q == full_mask;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    s_d         = s_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.start = 1'b1;
            k_d         = '0;
            s_d         = MAX_PEERS'(1);
            state_d     = S_STEP;
          end
        end
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        cmd_o.take = s_q[k_q];
        if (last_k) begin
          k_d     = '0;
          state_d = S_FMUL;
        end else begin
          k_d = k_q + IW'(1);
        end
      end
      S_FMUL: begin
        cmd_o.fin_mul = 1'b1;
        state_d       = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (last_s) begin
          state_d = S_PUSH;
        end else begin
          s_d     = s_q + MAX_PEERS'(1);
          state_d = S_STEP;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      k_q         <= '0;
      s_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      s_q         <= s_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign k_o         = k_q;
  assign subset_o    = s_q;

endmodule

// ===== hdl/min_expected_cost_subset_select_core.sv =====
// Minimum expected cost subset selector, top level.
// Non-last words are only stored; a last word with n stored candidates starts a
// search over all 2^n - 1 nonempty subsets, one candidate per step, each closed
// by a miss term and a compare; the result is posted once the output register is free.
// Throughput: one candidate word per cycle while loading; no input during search or while the result waits to post.
// Reset: asynchronous active low; clears counts, flags, output valid, penalty=1000.
module min_expected_cost_subset_select_core #(
  parameter int MAX_PEERS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mecss_in_if.sink          in_i,
  mecss_out_if.source       out_o,
  mecss_cfg_if.sink         cfg_i
);
  import mecss_pkg::*;

  // candidate index and load count widths
  localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CW = $clog2(MAX_PEERS + 1);

  mecss_cmd_t           cmd;
  logic [IW-1:0]        k;
  logic [MAX_PEERS-1:0] subset;
  logic [CW-1:0]        count;

  // penalty register is always writable; the host must write it only while idle (the block does not enforce this)
  assign cfg_i.ready = 1'b1;

  // Controller: load phase takes words; a last word kicks off the search.
  // Each subset walks all stored candidates (one multiply per step), then a miss
  // term step and a compare step.
  mecss_ctrl #(
    .MAX_PEERS (MAX_PEERS),
    .IW        (IW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.is_last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .count_i     (count),
    .cmd_o       (cmd),
    .k_o         (k),
    .subset_o    (subset)
  );

  // Datapath: store, running product and sum, best bound, output register.
  mecss_dp #(
    .MAX_PEERS (MAX_PEERS),
    .IW        (IW),
    .CW        (CW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .k_i           (k),
    .subset_i      (subset),
    .miss_prob_i   (in_i.miss_prob),
    .query_cost_i  (in_i.query_cost),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .count_o       (count),
    .chosen_mask_o (out_o.chosen_mask),
    .best_cost_o   (out_o.best_cost),
    .overflowed_o  (out_o.overflowed)
  );

endmodule
